// ===== src/avt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the affine vector transform.
// No dependencies; every other file of the block imports this package.
package avt_pkg;

   // Fixed-point format and operand widths
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int PAIR_W      = PROD_W + 1;
   localparam int SUM_W       = PROD_W + 2;
   localparam int SHIFT_W     = SUM_W - FRAC_BITS;

   // Matrix shape
   localparam int NUM_ROWS    = 3;
   localparam int NUM_COLS    = 4;
   localparam int NUM_PAIRS   = NUM_COLS / 2;

   // Control/status register file
   localparam int NUM_CSR     = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_PER_ROW = NUM_CSR / NUM_ROWS;
   localparam int COLS_PER_CSR = CSR_DATA_W / DATA_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW0_COLS01,
      CSR_ROW0_COLS23,
      CSR_ROW1_COLS01,
      CSR_ROW1_COLS23,
      CSR_ROW2_COLS01,
      CSR_ROW2_COLS23
   } csr_index_type;

   // Input word and result word
   typedef struct packed {
      logic signed [DATA_W-1:0] in_x;
      logic signed [DATA_W-1:0] in_y;
      logic signed [DATA_W-1:0] in_z;
      logic signed [DATA_W-1:0] in_w;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_x;
      logic signed [DATA_W-1:0] out_y;
      logic signed [DATA_W-1:0] out_z;
      logic                     saturated;
   } rsp_type;

   // One row of coefficients or one vector, column 0 in element 0
   typedef logic [NUM_COLS-1:0][DATA_W-1:0] word_row_type;
   typedef word_row_type [NUM_ROWS-1:0]     matrix_type;

   // Load enables for the three stages inside a row unit
   typedef struct packed {
      logic load_prod;
      logic load_pair;
      logic load_sum;
   } pipe_en_type;

   // Reset value of each register: identity rows
   function automatic logic [CSR_DATA_W-1:0] csr_reset_value(input csr_index_type idx);
      logic [CSR_DATA_W-1:0] one;
      one = CSR_DATA_W'(1) << FRAC_BITS;
      unique case (idx)
         CSR_ROW0_COLS01: csr_reset_value = one;
         CSR_ROW1_COLS01: csr_reset_value = one << DATA_W;
         CSR_ROW2_COLS23: csr_reset_value = one;
         default:         csr_reset_value = '0;
      endcase
   endfunction

endpackage

// ===== src/avt_csr_regs.sv =====
`timescale 1ns / 1ps
// Coefficient register file: six 64-bit registers written over the csr port.
// Depends on avt_pkg for widths, register indexes and reset values.
module avt_csr_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [avt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [avt_pkg::CSR_DATA_W-1:0]  csr_data,
   output avt_pkg::matrix_type            matrix
);
   import avt_pkg::*;

   logic [CSR_DATA_W-1:0] regs_ff [NUM_CSR];
   logic [CSR_DATA_W-1:0] regs_in [NUM_CSR];
   logic                  index_ok;

   // Drop writes to indexes past the last register
   assign index_ok = (csr_index < CSR_INDEX_W'(NUM_CSR));

   always_comb begin
      for (int k = 0; k < NUM_CSR; k++) begin
         regs_in[k] = regs_ff[k];
      end
      if (csr_valid && index_ok) begin
         regs_in[csr_index] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CSR; k++) begin
            regs_ff[k] <= csr_reset_value(csr_index_type'(CSR_INDEX_W'(k)));
         end
      end else begin
         for (int k = 0; k < NUM_CSR; k++) begin
            regs_ff[k] <= regs_in[k];
         end
      end
   end

   // Split each register into its two signed coefficients
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            matrix[r][c] = regs_ff[r * CSR_PER_ROW + c / COLS_PER_CSR]
                                  [(c % COLS_PER_CSR) * DATA_W +: DATA_W];
         end
      end
   end

endmodule

// ===== src/avt_row_dot.sv =====
`timescale 1ns / 1ps
// One matrix row against the vector: multiply, pairwise add, final add and
// floor shift, each behind its own register. Depends on avt_pkg.
module avt_row_dot (
   input  logic                               clock,
   input  avt_pkg::pipe_en_type               en,
   input  avt_pkg::word_row_type              coef,
   input  avt_pkg::word_row_type              vec,
   output logic signed [avt_pkg::SHIFT_W-1:0] shifted
);
   import avt_pkg::*;

   logic signed [PROD_W-1:0]  prod_ff [NUM_COLS];
   logic signed [PROD_W-1:0]  prod_in [NUM_COLS];
   logic signed [PAIR_W-1:0]  pair_ff [NUM_PAIRS];
   logic signed [PAIR_W-1:0]  pair_in [NUM_PAIRS];
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [SHIFT_W-1:0] shifted_ff;
   logic signed [SHIFT_W-1:0] shifted_in;

   // Full 64-bit products, one 32x32 multiplier per column
   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         prod_in[c] = $signed(coef[c]) * $signed(vec[c]);
      end
   end

   // Add products in pairs
   always_comb begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
         pair_in[k] = PAIR_W'(prod_ff[2 * k]) + PAIR_W'(prod_ff[2 * k + 1]);
      end
   end

   // Exact sum, then drop the fraction bits (floor toward minus infinity)
   assign sum_in     = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
   assign shifted_in = sum_in[SUM_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (en.load_prod) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            prod_ff[c] <= prod_in[c];
         end
      end
      if (en.load_pair) begin
         for (int k = 0; k < NUM_PAIRS; k++) begin
            pair_ff[k] <= pair_in[k];
         end
      end
      if (en.load_sum) begin
         shifted_ff <= shifted_in;
      end
   end

   assign shifted = shifted_ff;

endmodule

// ===== src/affine_vector_transform.sv =====
`timescale 1ns / 1ps
// Affine vector transform: multiplies a homogeneous Q16.16 vector (x, y, z, w)
// by the top three rows of a 4x4 coefficient matrix and returns the
// transformed x, y, z, each floored and saturated to 32 bits, with a flag
// when any component clipped. One word is accepted every cycle while the
// pipeline is not held by a stalled output, and passes through four register
// stages (multiply, pair add, final add and shift, saturate into the output
// register); throughput is one word per cycle when rsp_ready stays high,
// and the twelve 32x32 multipliers all run in the first stage.
// Matrix registers reset to identity and take effect on the next word; write
// them only while no word is in flight. Depends on avt_pkg, avt_csr_regs and
// avt_row_dot.
module affine_vector_transform (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  avt_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output avt_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [avt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [avt_pkg::CSR_DATA_W-1:0]  csr_data
);
   import avt_pkg::*;

   localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   matrix_type                matrix;
   word_row_type              vec;
   pipe_en_type               pipe_en;
   logic signed [SHIFT_W-1:0] shifted [NUM_ROWS];
   logic [DATA_W-1:0]         word_out [NUM_ROWS];
   logic [NUM_ROWS-1:0]       clipped;

   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, rsp_valid_in;
   logic s1_load, s2_load, s3_load, out_load;
   rsp_type rsp_ff, rsp_in;

   // Register file; writes are always accepted
   assign csr_ready = 1'b1;

   avt_csr_regs u_csr_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .matrix    (matrix)
   );

   // Pipeline advance: a stage loads when empty or when the next one loads
   assign out_load = !rsp_valid_ff || rsp_ready;
   assign s3_load  = !v3_ff || out_load;
   assign s2_load  = !v2_ff || s3_load;
   assign s1_load  = !v1_ff || s2_load;
   assign req_ready = s1_load;

   assign v1_in        = s1_load  ? req_valid : v1_ff;
   assign v2_in        = s2_load  ? v1_ff     : v2_ff;
   assign v3_in        = s3_load  ? v2_ff     : v3_ff;
   assign rsp_valid_in = out_load ? v3_ff     : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign pipe_en.load_prod = s1_load && req_valid;
   assign pipe_en.load_pair = s2_load && v1_ff;
   assign pipe_en.load_sum  = s3_load && v2_ff;

   // Vector columns in x, y, z, w order
   assign vec[0] = req_data.in_x;
   assign vec[1] = req_data.in_y;
   assign vec[2] = req_data.in_z;
   assign vec[3] = req_data.in_w;

   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
      avt_row_dot u_row_dot (
         .clock   (clock),
         .en      (pipe_en),
         .coef    (matrix[r]),
         .vec     (vec),
         .shifted (shifted[r])
      );
   end

   // Saturate: in range when all bits from the sign of a 32-bit word up agree
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         clipped[r] = !((&shifted[r][SHIFT_W-1:DATA_W-1]) ||
                        !(|shifted[r][SHIFT_W-1:DATA_W-1]));
         if (!clipped[r]) begin
            word_out[r] = shifted[r][DATA_W-1:0];
         end else if (shifted[r][SHIFT_W-1]) begin
            word_out[r] = WORD_MIN;
         end else begin
            word_out[r] = WORD_MAX;
         end
      end
      rsp_in.out_x     = word_out[0];
      rsp_in.out_y     = word_out[1];
      rsp_in.out_z     = word_out[2];
      rsp_in.saturated = |clipped;
   end

   // Output register; holds while the consumer stalls
   always_ff @(posedge clock) begin
      if (out_load && v3_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted word always lands in the first stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted word did not enter the first stage");

   // Back-pressure only when every stage holds a word
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff))
      else $error("input stalled with a free pipeline slot");

   // A stalled last stage keeps its word
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !out_load |=> v3_ff && $stable(shifted[0]))
      else $error("last stage lost its word under stall");

   // A saturated flag means some component sits at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         (rsp_data.out_x == WORD_MAX || rsp_data.out_x == WORD_MIN ||
          rsp_data.out_y == WORD_MAX || rsp_data.out_y == WORD_MIN ||
          rsp_data.out_z == WORD_MAX || rsp_data.out_z == WORD_MIN))
      else $error("saturated flag without a clipped component");

endmodule
